// ===== src/fba_pkg.sv =====
// fba_pkg: widths, command codes, fit mode codes and register indexes
// for the fit block allocator. No dependencies.
package fba_pkg;

   // Transaction field widths
   localparam int CMD_W          = 1;
   localparam int BLOCK_INDEX_W  = 4;
   localparam int SIZE_VALUE_W   = 16;
   localparam int GRANTED_W      = 1;
   localparam int CHOSEN_BLOCK_W = 4;

   // Configuration registers
   localparam int FIT_MODE_W     = 2;
   localparam int NUM_BLOCKS_W   = 5;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_MODE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_BLOCKS = 1'b1;

   localparam logic [FIT_MODE_W-1:0]   FIT_MODE_RST   = 2'd0;
   localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RST = 5'd16;

   // Fit modes; the unused code behaves as first fit
   localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

   // Parameter defaults
   localparam int NUM_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== src/fba_req_if.sv =====
// fba_req_if: request channel (load or allocate) with valid/ready.
// Depends on fba_pkg.
interface fba_req_if
   import fba_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [BLOCK_INDEX_W-1:0] block_index;
   logic [SIZE_VALUE_W-1:0]  size_value;

   modport source (output valid, cmd, block_index, size_value, input ready);
   modport sink   (input valid, cmd, block_index, size_value, output ready);
endinterface

// ===== src/fba_rsp_if.sv =====
// fba_rsp_if: allocation response channel with valid/ready.
// Depends on fba_pkg.
interface fba_rsp_if
   import fba_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [GRANTED_W-1:0]      granted;
   logic [CHOSEN_BLOCK_W-1:0] chosen_block;

   modport source (output valid, granted, chosen_block, input ready);
   modport sink   (input valid, granted, chosen_block, output ready);
endinterface

// ===== src/fba_csr_if.sv =====
// fba_csr_if: configuration register write channel with valid/ready.
// Depends on fba_pkg.
interface fba_csr_if
   import fba_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/fba_ram.sv =====
// fba_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module fba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/fit_block_allocator_top.sv =====
// fit_block_allocator_top: first / best / worst fit block allocator.
// Depends on fba_pkg, fba_req_if, fba_rsp_if, fba_csr_if and fba_ram.
//
// The block holds the remaining free size of NUM_BLOCKS memory blocks in one
// RAM with a registered read. After reset a clearing pass writes zero to
// every entry, one per cycle, so the request channel is held off until the
// pass ends (configuration writes are taken throughout). A load transaction
// writes one entry in the cycle it is accepted and produces no response; a
// load whose block_index is NUM_BLOCKS or more is dropped. An allocate
// transaction scans the first n = min(num_blocks, NUM_BLOCKS) entries, one
// RAM read per cycle, picking the lowest index (first fit, also the unused
// mode code), the smallest fitting size (best fit) or the largest fitting
// size (worst fit), ties to the lowest index. The chosen entry is written
// back reduced by the request size, and the response carries granted and
// chosen_block (low 4 bits of the index, 0 when not granted). An allocate
// reads through the single RAM read port, compares each entry once its
// registered read data returns, then writes back; the next request is
// accepted once the block is idle again. One allocate is in flight at a
// time, so scan reads and the write-back never overlap on an entry. The
// response sits in an output register, so a new request may be accepted
// while it waits; the write-back of the following allocate waits until
// that register frees up. The csr channel is always ready.
module fit_block_allocator_top
   import fba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   fba_req_if.sink  req_if,
   fba_rsp_if.source rsp_if,
   fba_csr_if.sink  csr_if
);
   localparam int ADDR_BITS = $clog2(NUM_BLOCKS);
   localparam int CNT_BITS  = ADDR_BITS + 1;
   localparam int NCMP_W    = max_int(CNT_BITS, NUM_BLOCKS_W);
   localparam int IDX_W     = max_int(ADDR_BITS, BLOCK_INDEX_W);
   localparam int CMP_BITS  = max_int(SIZE_BITS, SIZE_VALUE_W);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   // Registers
   state_type               state_ff,     state_in;
   logic [FIT_MODE_W-1:0]   fit_mode_ff,  fit_mode_in;
   logic [NUM_BLOCKS_W-1:0] num_blocks_ff, num_blocks_in;
   logic [ADDR_BITS-1:0]    clr_ff,       clr_in;
   logic [CNT_BITS-1:0]     n_ff,         n_in;
   logic [CNT_BITS-1:0]     rd_ff,        rd_in;
   logic                    data_vld_ff,  data_vld_in;
   logic [ADDR_BITS-1:0]    data_idx_ff,  data_idx_in;
   logic [SIZE_VALUE_W-1:0] size_ff,      size_in;
   logic [FIT_MODE_W-1:0]   mode_ff,      mode_in;
   logic                    found_ff,     found_in;
   logic [ADDR_BITS-1:0]    pick_ff,      pick_in;
   logic [SIZE_BITS-1:0]    pick_val_ff,  pick_val_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [GRANTED_W-1:0]    rsp_granted_ff, rsp_granted_in;
   logic [CHOSEN_BLOCK_W-1:0] rsp_chosen_ff, rsp_chosen_in;

   // RAM port signals
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [SIZE_BITS-1:0] rd_data;

   // Combinational helpers
   logic                 req_fire;
   logic                 rsp_free;
   logic [IDX_W-1:0]     idx_ext;
   logic                 load_in_range;
   logic [CMP_BITS-1:0]  load_ext;
   logic [NCMP_W-1:0]    nb_ext;
   logic [NCMP_W-1:0]    n_lim;
   logic [NCMP_W-1:0]    n_sel;
   logic                 fits;
   logic                 better;
   logic                 last_data;
   logic [CMP_BITS-1:0]  diff;
   logic [IDX_W-1:0]     pick_ext;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.granted      = rsp_granted_ff;
   assign rsp_if.chosen_block = rsp_chosen_ff;

   // Load decode
   assign idx_ext       = IDX_W'(req_if.block_index);
   assign load_in_range = {1'b0, idx_ext} < (IDX_W + 1)'(NUM_BLOCKS);
   assign load_ext      = CMP_BITS'(req_if.size_value);

   // Search count: min(num_blocks, NUM_BLOCKS)
   assign nb_ext = NCMP_W'(num_blocks_ff);
   assign n_lim  = NCMP_W'(NUM_BLOCKS);
   assign n_sel  = (nb_ext > n_lim) ? n_lim : nb_ext;

   // Scan compare on the entry whose read data is now valid
   assign fits = CMP_BITS'(rd_data) >= CMP_BITS'(size_ff);
   always_comb begin
      priority if (!found_ff) begin
         better = 1'b1;
      end else if (mode_ff == FIT_BEST) begin
         better = rd_data < pick_val_ff;
      end else if (mode_ff == FIT_WORST) begin
         better = rd_data > pick_val_ff;
      end else begin
         better = 1'b0;
      end
   end
   assign last_data = data_vld_ff && (({1'b0, data_idx_ff} + CNT_BITS'(1)) == n_ff);

   assign diff     = CMP_BITS'(pick_val_ff) - CMP_BITS'(size_ff);
   assign pick_ext = IDX_W'(pick_ff);

   always_comb begin
      state_in       = state_ff;
      fit_mode_in    = fit_mode_ff;
      num_blocks_in  = num_blocks_ff;
      clr_in         = clr_ff;
      n_in           = n_ff;
      rd_in          = rd_ff;
      data_vld_in    = 1'b0;
      data_idx_in    = rd_ff[ADDR_BITS-1:0];
      size_in        = size_ff;
      mode_in        = mode_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      pick_val_in    = pick_val_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      wr_en          = 1'b0;
      wr_addr        = clr_ff;
      wr_data        = '0;
      rd_en          = 1'b0;

      // Configuration writes, taken in any state
      if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_FIT_MODE:   fit_mode_in   = csr_if.data[FIT_MODE_W-1:0];
            CSR_NUM_BLOCKS: num_blocks_in = csr_if.data[NUM_BLOCKS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_BITS'(1);
            if ({1'b0, clr_ff} == CNT_BITS'(NUM_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.cmd == CMD_LOAD) begin
                  wr_en   = load_in_range;
                  wr_addr = idx_ext[ADDR_BITS-1:0];
                  wr_data = load_ext[SIZE_BITS-1:0];
               end else begin
                  size_in  = req_if.size_value;
                  mode_in  = fit_mode_ff;
                  n_in     = n_sel[CNT_BITS-1:0];
                  rd_in    = '0;
                  found_in = 1'b0;
                  pick_in  = '0;
                  state_in = (n_sel == '0) ? ST_WRITE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle until n entries are requested
            if (rd_ff < n_ff) begin
               rd_en       = 1'b1;
               data_vld_in = 1'b1;
               rd_in       = rd_ff + CNT_BITS'(1);
            end
            if (data_vld_ff && fits && better) begin
               found_in    = 1'b1;
               pick_in     = data_idx_ff;
               pick_val_in = rd_data;
            end
            if (last_data) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               wr_en          = found_ff;
               wr_addr        = pick_ff;
               wr_data        = diff[SIZE_BITS-1:0];
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_chosen_in  = found_ff ? pick_ext[CHOSEN_BLOCK_W-1:0] : '0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         fit_mode_ff   <= FIT_MODE_RST;
         num_blocks_ff <= NUM_BLOCKS_RST;
         clr_ff        <= '0;
         data_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fit_mode_ff   <= fit_mode_in;
         num_blocks_ff <= num_blocks_in;
         clr_ff        <= clr_in;
         data_vld_ff   <= data_vld_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff           <= n_in;
      rd_ff          <= rd_in;
      data_idx_ff    <= data_idx_in;
      size_ff        <= size_in;
      mode_ff        <= mode_in;
      pick_ff        <= pick_in;
      pick_val_ff    <= pick_val_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_chosen_ff  <= rsp_chosen_in;
   end

   fba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   // No RAM write may land while a scan is reading the table
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !wr_en)
      else $error("RAM write during scan");

   // A held pick always fits the request it was chosen for
   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (found_ff && (state_ff == ST_SCAN || state_ff == ST_WRITE))
         |-> (CMP_BITS'(pick_val_ff) >= CMP_BITS'(size_ff)))
      else $error("picked entry smaller than request");

   // Read data is only consumed in the cycle after a scan read was issued
   a_data_follows_read: assert property (@(posedge clock) disable iff (reset)
      data_vld_ff |-> ($past(rd_en) && $past(state_ff == ST_SCAN)))
      else $error("scan data valid without a read");

   // A denied response carries index zero
   a_deny_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_granted_ff == '0)) |-> (rsp_chosen_ff == '0))
      else $error("denied response with nonzero index");
endmodule

// ===== dv/tb_fit_block_allocator_top.sv =====
`timescale 1ns / 100ps
// tb_fit_block_allocator_top: self-checking bench for the first/best/worst fit allocator.
// Depends on fba_pkg, fba_req_if, fba_rsp_if, fba_csr_if and fit_block_allocator_top.
module tb_fit_block_allocator_top;
   import fba_pkg::*;

   localparam int NBLK          = NUM_BLOCKS_DEF;
   localparam int RESET_CYCLES  = 11;
   localparam int CYCLE_LIMIT   = 200000;
   // sized from NBLK so that a trailing load or allocate can finish
   localparam int SETTLE_CYCLES = NBLK + 8;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 80;
   localparam int DIRECTED_ROWS = 21;

   // unused mode code, handled as first fit
   localparam logic [FIT_MODE_W-1:0] FIT_UNUSED = 2'd3;

   typedef struct packed {
      logic                      granted;
      logic [CHOSEN_BLOCK_W-1:0] chosen_block;
   } grant_type;

   typedef struct {
      logic [CMD_W-1:0]         cmd;
      logic [BLOCK_INDEX_W-1:0] block_index;
      logic [SIZE_VALUE_W-1:0]  size_value;
      bit                       typed;   // expectation given in the row
      grant_type                grant;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   fba_req_if req_ch ();
   fba_rsp_if rsp_ch ();
   fba_csr_if csr_ch ();

   fit_block_allocator_top #(
      .NUM_BLOCKS (NUM_BLOCKS_DEF),
      .SIZE_BITS  (SIZE_BITS_DEF)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Shadow copy of the free-size table and of both registers
   logic [SIZE_VALUE_W-1:0] shadow_free [NBLK];
   logic [FIT_MODE_W-1:0]   shadow_mode;
   logic [NUM_BLOCKS_W-1:0] shadow_count;

   // Grants still owed by the DUT, oldest first
   grant_type pending_grants [$];

   int  errors      = 0;
   int  n_loads     = 0;
   int  n_allocs    = 0;
   int  n_granted   = 0;
   int  n_refused   = 0;
   int  cycle_count = 0;
   bit  quiet       = 1'b0;   // when set, neither side inserts gaps

   // Directed table, run under the reset settings (first fit, 16 blocks, empty table).
   // Rows with typed set carry an expectation read straight off the spec;
   // the rest are left to the predictor.
   stim_row_type directed [DIRECTED_ROWS] = '{
      // empty table refuses any nonzero request
      '{CMD_ALLOC, 4'd0,  16'd1,      1'b1, '{1'b0, 4'd0}},
      // zero request fits an empty entry; block_index ignored on allocate
      '{CMD_ALLOC, 4'd5,  16'd0,      1'b1, '{1'b1, 4'd0}},
      '{CMD_LOAD,  4'd15, 16'hFFFF,   1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'hFFFF,   1'b1, '{1'b1, 4'd15}},
      '{CMD_ALLOC, 4'd0,  16'd1,      1'b1, '{1'b0, 4'd0}},
      '{CMD_LOAD,  4'd0,  16'd100,    1'b0, '{1'b0, 4'd0}},
      '{CMD_LOAD,  4'd3,  16'd50,     1'b0, '{1'b0, 4'd0}},
      '{CMD_LOAD,  4'd7,  16'd200,    1'b0, '{1'b0, 4'd0}},
      '{CMD_LOAD,  4'd9,  16'hAAAA,   1'b0, '{1'b0, 4'd0}},
      '{CMD_LOAD,  4'd10, 16'h5555,   1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd15, 16'd40,     1'b1, '{1'b1, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'd60,     1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'd60,     1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'd0,      1'b1, '{1'b1, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'hAAAA,   1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'h5556,   1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'h5555,   1'b0, '{1'b0, 4'd0}},
      '{CMD_LOAD,  4'd1,  16'hFFFF,   1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'hFFFF,   1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'd50,     1'b0, '{1'b0, 4'd0}},
      '{CMD_ALLOC, 4'd0,  16'd141,    1'b0, '{1'b0, 4'd0}}
   };

   // Register settings per phase; the last phase draws its own
   logic [FIT_MODE_W-1:0] phase_mode [PHASES] = '{
      FIT_BEST, FIT_WORST, FIT_FIRST, FIT_UNUSED, FIT_BEST,
      FIT_WORST, FIT_WORST, FIT_BEST, FIT_FIRST, FIT_FIRST
   };
   int phase_blocks [PHASES] = '{16, 16, 1, 12, 31, 0, 5, 2, 17, 16};

   // Fit search on the shadow table; updates the chosen entry
   function automatic grant_type allocate_fit(logic [SIZE_VALUE_W-1:0] request);
      int        span;
      int        pick;
      bit        found;
      grant_type g;
      span  = (shadow_count > NBLK) ? NBLK : int'(shadow_count);
      pick  = 0;
      found = 1'b0;
      for (int j = 0; j < span; j++) begin
         if (shadow_free[j] >= request) begin
            if (!found) begin
               found = 1'b1;
               pick  = j;
            end else if (shadow_mode == FIT_BEST && shadow_free[j] < shadow_free[pick]) begin
               pick = j;
            end else if (shadow_mode == FIT_WORST && shadow_free[j] > shadow_free[pick]) begin
               pick = j;
            end
         end
      end
      if (found) begin
         shadow_free[pick] = shadow_free[pick] - request;
         g.granted         = 1'b1;
         g.chosen_block    = CHOSEN_BLOCK_W'(pick);
      end else begin
         g = '0;
      end
      return g;
   endfunction

   // Drive one request transaction; starts and ends on a falling edge.
   // valid is left high so back-to-back items need no extra edge.
   task automatic send_request(input logic [CMD_W-1:0]         cmd,
                               input logic [BLOCK_INDEX_W-1:0] idx,
                               input logic [SIZE_VALUE_W-1:0]  size,
                               input bit                       typed,
                               input grant_type                typed_grant);
      int        gap;
      grant_type g;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.block_index <= idx;
      req_ch.size_value  <= size;
      do @(posedge clock); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
      // accepted: advance the shadow state in acceptance order
      if (cmd == CMD_LOAD) begin
         shadow_free[idx] = size;
         n_loads++;
      end else begin
         g = allocate_fit(size);
         pending_grants.push_back(typed ? typed_grant : g);
         n_allocs++;
      end
      @(negedge clock);
   endtask

   // One register write; valid is left high for the caller to drop
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1));
      if (idx == CSR_FIT_MODE)
         shadow_mode = value[FIT_MODE_W-1:0];
      else
         shadow_count = value[NUM_BLOCKS_W-1:0];
      @(negedge clock);
   endtask

   // Wait for every owed grant, then let a trailing load or scan finish
   task automatic wait_idle();
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Random traffic: mostly allocations sized against the live table so
   // grants are common, plus loads that refill it. A few distinct load
   // sizes create ties for best and worst fit.
   task automatic run_random(input int count);
      int                       pick_kind;
      logic [BLOCK_INDEX_W-1:0] idx;
      logic [BLOCK_INDEX_W-1:0] peek;
      logic [SIZE_VALUE_W-1:0]  size;
      for (int k = 0; k < count; k++) begin
         pick_kind = $urandom_range(0, 99);
         idx       = BLOCK_INDEX_W'($urandom_range(0, NBLK - 1));
         if (pick_kind < 40) begin
            case ($urandom_range(0, 3))
               0:       size = SIZE_VALUE_W'($urandom_range(0, 65535));
               1:       size = SIZE_VALUE_W'($urandom_range(0, 8) * 16);
               default: size = SIZE_VALUE_W'($urandom_range(1, 2000));
            endcase
            send_request(CMD_LOAD, idx, size, 1'b0, '0);
         end else begin
            peek = BLOCK_INDEX_W'($urandom_range(0, NBLK - 1));
            case ($urandom_range(0, 7))
               0:       size = '0;
               1:       size = SIZE_VALUE_W'($urandom_range(0, 65535));
               2:       size = shadow_free[peek] + 1'b1;   // just too big for that entry
               default: size = SIZE_VALUE_W'($urandom_range(0, shadow_free[peek]));
            endcase
            send_request(CMD_ALLOC, idx, size, 1'b0, '0);
         end
      end
   endtask

   // Response side: after each transaction draw a stall; a stall only
   // starts counting once a response is presented, so the output register
   // really backs up and the next allocate's write-back has to wait.
   initial begin : rsp_pacing
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            do @(posedge clock); while (rsp_ch.valid !== 1'b1);
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
         @(negedge clock);
      end
   end

   // Response checker: every accepted response against the oldest grant owed
   always @(posedge clock) begin : check_grants
      grant_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (rsp_ch.granted === 1'b1) n_granted++;
         else                         n_refused++;
         if (pending_grants.size() == 0) begin
            errors++;
            $display("%0t: response with none owed, granted %0b chosen_block %0d",
                     $time, rsp_ch.granted, rsp_ch.chosen_block);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_ch.granted !== want.granted) begin
               errors++;
               $display("%0t: granted expected %0b actual %0b",
                        $time, want.granted, rsp_ch.granted);
            end
            if (rsp_ch.chosen_block !== want.chosen_block) begin
               errors++;
               $display("%0t: chosen_block expected %0d actual %0d",
                        $time, want.chosen_block, rsp_ch.chosen_block);
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d grants still owed", $time, pending_grants.size());
      $display("DONE: errors detected");
      $finish;
   end

   // Main sequence
   initial begin : stimulus
      logic [FIT_MODE_W-1:0] mode;
      int                    blocks;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_LOAD;
      req_ch.block_index = '0;
      req_ch.size_value  = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_FIT_MODE;
      csr_ch.data        = '0;
      shadow_mode        = FIT_MODE_RST;
      shadow_count       = NUM_BLOCKS_RST;
      foreach (shadow_free[i]) shadow_free[i] = '0;

      // synchronous reset; the DUT then clears its table and holds off requests
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part under the reset register values
      foreach (directed[i])
         send_request(directed[i].cmd, directed[i].block_index, directed[i].size_value,
                      directed[i].typed, directed[i].grant);
      req_ch.valid <= 1'b0;
      wait_idle();

      // random phases, registers rewritten only while the DUT is idle
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            mode   = FIT_MODE_W'($urandom_range(0, 3));
            blocks = $urandom_range(0, 31);
         end else begin
            mode   = phase_mode[p];
            blocks = phase_blocks[p];
         end
         csr_write(CSR_FIT_MODE, CSR_DATA_W'(mode));
         csr_write(CSR_NUM_BLOCKS, CSR_DATA_W'(blocks));
         csr_ch.valid <= 1'b0;
         // every third phase runs back to back on both sides
         quiet = (p % 3 == 2);
         run_random(PHASE_ITEMS);
         req_ch.valid <= 1'b0;
         wait_idle();
      end

      $display("Ran %0d loads and %0d allocations (%0d granted, %0d refused)",
               n_loads, n_allocs, n_granted, n_refused);
      $display("across %0d register settings incl. unused mode and 0/oversized block counts",
               PHASES + 1);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
